// ===== hdl/disk_block_cache_tags_top_assert.svh =====
// Assertion macros for the disk block cache tag controller.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DISK_BLOCK_CACHE_TAGS_TOP_ASSERT_SVH
`define DISK_BLOCK_CACHE_TAGS_TOP_ASSERT_SVH

// The condition and the expression are checked in the same cycle.
`define DBCT_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// The expression is checked in the cycle after the condition.
`define DBCT_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== hdl/dbct_pkg.sv =====
// Shared types and constants for the disk block cache tag controller.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package dbct_pkg;

  localparam int DEFAULT_ENTRIES = 64;

  // Slot mapping and buffer layout.
  localparam int DevStride   = 100;
  localparam int SlotsPerRow = 8;
  localparam int RowStep     = 16;
  localparam int BlockBytes  = 512;

  localparam logic [15:0] BPC_RESET = 16'd64;

  // 17 bits cover the slot sum 100 * device + block, and they keep the
  // track divider's partial remainder whole for any 16-bit divisor.
  localparam int DIV_NW = 17;
  localparam int DIV_DW = 16;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SYNC  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    REG_BUFFER_BASE  = 3'd0,
    REG_BPC          = 3'd1,
    REG_TRACK_OFFSET = 3'd2,
    REG_DEV1_OFFSET  = 3'd3,
    REG_DEV2_OFFSET  = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_MOD_FIX,
    S_TAG_RD,
    S_TAG_CHK,
    S_WB_DIV,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic [1:0]  device;
    logic [15:0] block;
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
    logic [DIV_NW-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== hdl/dbct_tag_ram.sv =====
// Tag memory: one write port and one read port with registered read data.
// Depends on dbct_pkg for the default depth and width.
`timescale 1ns / 1ps

module dbct_tag_ram
  import dbct_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES,
  parameter int WIDTH = TAG_W,
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/dbct_divider.sv =====
// Restoring divider, one quotient bit per cycle, used for the track and
// sector split of a written-back block. Depends on dbct_pkg.
`timescale 1ns / 1ps

module dbct_divider
  import dbct_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              running;
  logic              done;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_NW-1:0] rem;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] dv;
  logic [DIV_NW-1:0] trial;
  logic              take;

  // The partial remainder stays below twice the divisor, so dropping its
  // top bit on the shift loses nothing. With a zero divisor every step
  // subtracts zero: the quotient becomes all ones and the remainder the
  // dividend.
  always_comb begin
    trial = {rem[DIV_NW-2:0], quo[DIV_NW-1]};
    take  = (trial >= {1'b0, dv});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == DIV_CW'(1));
      if (req.start) begin
        running <= 1'b1;
        cnt     <= DIV_CW'(DIV_NW);
      end else if (running) begin
        cnt <= cnt - DIV_CW'(1);
        if (cnt == DIV_CW'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dv  <= req.divisor;
    end else if (running) begin
      rem <= take ? (trial - {1'b0, dv}) : trial;
      quo <= {quo[DIV_NW-2:0], take};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== hdl/disk_block_cache_tags_top.sv =====
// Top level of the disk block cache tag controller: sequencer, registers
// and result formatting. Depends on dbct_pkg, dbct_tag_ram, dbct_divider.
`timescale 1ns / 1ps

// A request is taken at a rising edge with start high and busy low, and its
// single result appears for exactly one cycle with done high; the receiver
// cannot stall, so results must be captured in that cycle. The block works
// on one request at a time. Slot tags live in one synchronous memory with a
// registered read, and a restoring divider produces one quotient bit per
// cycle for the track and sector split. A read lookup goes through these
// steps from the accepting edge to the end of its done cycle: estimate the
// quotient of device times 100 plus block by ENTRIES with a reciprocal
// multiplication, correct it into the slot index, read the tag, compare,
// and present the result. A write or fill takes the same steps, and if it
// evicts a dirty block it also waits for the track and sector division
// before the result. A sync step scans the memory from its saved pointer,
// reading and checking one clean slot after another, and waits for the
// division of the first dirty one it finds; when it runs past the last slot
// it returns sync_done and rewinds the pointer. After reset a clearing pass
// invalidates every slot while busy stays high; configuration writes are
// taken at any time and should be made only while the block is idle. A
// blocks_per_cylinder of zero yields a track quotient of 0xFFFF and the
// block number as sector.

module disk_block_cache_tags_top
  import dbct_pkg::*;
#(
  parameter int ENTRIES = DEFAULT_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [1:0]  device,
  input  logic [15:0] block,
  input  logic        mark_dirty,
  output logic        done,
  output logic        hit,
  output logic [15:0] buf_high,
  output logic [11:0] buf_low,
  output logic        wb_valid,
  output logic [1:0]  wb_device,
  output logic [15:0] wb_track,
  output logic [15:0] wb_sector,
  output logic [15:0] wb_buf_high,
  output logic [11:0] wb_buf_low,
  output logic        sync_done,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  `include "disk_block_cache_tags_top_assert.svh"

  // Slot index width and a scan pointer wide enough to hold ENTRIES itself.
  localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW = $clog2(ENTRIES + 1);

  // Reciprocal of ENTRIES scaled by 2^17. For a 17-bit sum the estimated
  // quotient is at most one below the true one, so one conditional
  // subtract of ENTRIES finishes the remainder.
  localparam int MOD_MW = DIV_NW + 1;
  localparam int MW     = 2 * DIV_NW;
  localparam logic [MOD_MW-1:0] MOD_M = MOD_MW'((1 << DIV_NW) / ENTRIES);

  state_t state, state_next;

  // Request captured at acceptance.
  opcode_t     op;
  logic [1:0]  dev;
  logic [15:0] blk;
  logic        mark;

  logic [SW-1:0] slot;
  logic [SW-1:0] clr_cnt;
  logic [PW-1:0] ptr;
  tag_t          old_tag;

  // Slot mapping datapath.
  logic [DIV_NW-1:0] mod_sum;
  logic [DIV_NW-1:0] mod_q;
  logic [MW-1:0]     mod_prod;
  logic [DIV_NW-1:0] mod_qd;
  logic [DIV_NW-1:0] mod_r0;
  logic [DIV_NW-1:0] mod_rem;

  // Configuration registers.
  logic [15:0] buffer_base;
  logic [15:0] blocks_per_cylinder;
  logic [15:0] track_offset;
  logic [15:0] dev1_track_offset;
  logic [15:0] dev2_track_offset;

  // Memory and divider connections.
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  tag_t          mem_wdata;
  logic [SW-1:0] mem_raddr;
  logic [TAG_W-1:0] mem_rdata;
  tag_t          rd_tag;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  logic        hit_now;
  logic        rd_dirty;
  logic        scan_end;
  logic [15:0] dev_offset;
  logic [15:0] slot16;

  dbct_tag_ram #(
    .ENTRIES (ENTRIES),
    .WIDTH   (TAG_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dbct_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  function automatic logic [15:0] slot_high(input logic [15:0] base, input logic [15:0] s);
    return base + 16'((s / SlotsPerRow) * RowStep);
  endfunction

  function automatic logic [11:0] slot_low(input logic [15:0] s);
    return 12'((s % SlotsPerRow) * BlockBytes);
  endfunction

  assign rd_tag   = tag_t'(mem_rdata);
  assign hit_now  = rd_tag.valid && (rd_tag.block == blk) && (rd_tag.device == dev);
  assign rd_dirty = rd_tag.valid && rd_tag.dirty;
  assign scan_end = (ptr == PW'(ENTRIES));
  assign slot16   = 16'(slot);

  assign mod_prod = MW'(mod_sum) * MW'(MOD_M);
  assign mod_qd   = DIV_NW'(mod_q * DIV_NW'(ENTRIES));
  assign mod_r0   = mod_sum - mod_qd;
  assign mod_rem  = (mod_r0 >= DIV_NW'(ENTRIES)) ? (mod_r0 - DIV_NW'(ENTRIES)) : mod_r0;

  // Device three, like device zero, gets no extra track offset.
  always_comb begin
    case (old_tag.device)
      2'd1:    dev_offset = dev1_track_offset;
      2'd2:    dev_offset = dev2_track_offset;
      default: dev_offset = 16'd0;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_REPLY);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == SW'(ENTRIES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (opcode_t'(opcode))
            OP_READ:  state_next = S_MOD;
            OP_WRITE: state_next = S_MOD;
            OP_SYNC:  state_next = S_SCAN_RD;
            default:  state_next = S_REPLY;
          endcase
        end
      end
      S_MOD: begin
        state_next = S_MOD_FIX;
      end
      S_MOD_FIX: begin
        state_next = S_TAG_RD;
      end
      S_TAG_RD: begin
        state_next = S_TAG_CHK;
      end
      S_TAG_CHK: begin
        if (op == OP_WRITE && !hit_now && rd_dirty) begin
          state_next = S_WB_DIV;
        end else begin
          state_next = S_REPLY;
        end
      end
      S_WB_DIV: begin
        if (div_rsp.done) begin
          state_next = S_REPLY;
        end
      end
      S_SCAN_RD: begin
        state_next = scan_end ? S_REPLY : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        state_next = rd_dirty ? S_WB_DIV : S_SCAN_RD;
      end
      S_REPLY: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Memory and divider control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = '0;
    mem_raddr = slot;
    div_req   = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      S_TAG_CHK: begin
        if (op == OP_WRITE) begin
          if (hit_now) begin
            // A write hit keeps the tag and can only set the dirty bit.
            if (mark) begin
              mem_we          = 1'b1;
              mem_wdata       = rd_tag;
              mem_wdata.dirty = 1'b1;
            end
          end else begin
            mem_we           = 1'b1;
            mem_wdata.valid  = 1'b1;
            mem_wdata.dirty  = mark;
            mem_wdata.device = dev;
            mem_wdata.block  = blk;
            if (rd_dirty) begin
              div_req.start    = 1'b1;
              div_req.dividend = DIV_NW'(rd_tag.block);
              div_req.divisor  = blocks_per_cylinder;
            end
          end
        end
      end
      S_SCAN_RD: begin
        mem_raddr = ptr[SW-1:0];
      end
      S_SCAN_CHK: begin
        if (rd_dirty) begin
          mem_we          = 1'b1;
          mem_waddr       = ptr[SW-1:0];
          mem_wdata       = rd_tag;
          mem_wdata.dirty = 1'b0;
          div_req.start    = 1'b1;
          div_req.dividend = DIV_NW'(rd_tag.block);
          div_req.divisor  = blocks_per_cylinder;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      ptr     <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + SW'(1);
      end
      if (state == S_SCAN_RD && scan_end) begin
        ptr <= '0;
      end
      // The pointer stays on a dirty slot: the next sync step sees it clean.
      if (state == S_SCAN_CHK && !rd_dirty) begin
        ptr <= ptr + PW'(1);
      end
    end
  end

  // Configuration registers; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_base         <= 16'd0;
      blocks_per_cylinder <= BPC_RESET;
      track_offset        <= 16'd0;
      dev1_track_offset   <= 16'd0;
      dev2_track_offset   <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BUFFER_BASE:  buffer_base         <= cfg_data;
        REG_BPC:          blocks_per_cylinder <= cfg_data;
        REG_TRACK_OFFSET: track_offset        <= cfg_data;
        REG_DEV1_OFFSET:  dev1_track_offset   <= cfg_data;
        REG_DEV2_OFFSET:  dev2_track_offset   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Request capture, working registers and result fields. Every result
  // field is cleared when a request is taken, so fields that do not apply
  // read as zero.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          op          <= opcode_t'(opcode);
          dev         <= device;
          blk         <= block;
          mark        <= mark_dirty;
          mod_sum     <= DIV_NW'(block) + DIV_NW'(device) * DIV_NW'(DevStride);
          hit         <= 1'b0;
          buf_high    <= 16'd0;
          buf_low     <= 12'd0;
          wb_valid    <= 1'b0;
          wb_device   <= 2'd0;
          wb_track    <= 16'd0;
          wb_sector   <= 16'd0;
          wb_buf_high <= 16'd0;
          wb_buf_low  <= 12'd0;
          sync_done   <= 1'b0;
        end
      end
      S_MOD: begin
        mod_q <= mod_prod[MW-1:DIV_NW];
      end
      S_MOD_FIX: begin
        slot <= mod_rem[SW-1:0];
      end
      S_TAG_CHK: begin
        hit      <= hit_now;
        buf_high <= slot_high(buffer_base, slot16);
        buf_low  <= slot_low(slot16);
        old_tag  <= rd_tag;
      end
      S_SCAN_RD: begin
        if (scan_end) begin
          sync_done <= 1'b1;
        end
      end
      S_SCAN_CHK: begin
        if (rd_dirty) begin
          old_tag <= rd_tag;
          slot    <= ptr[SW-1:0];
        end
      end
      S_WB_DIV: begin
        if (div_rsp.done) begin
          wb_valid    <= 1'b1;
          wb_device   <= old_tag.device;
          wb_track    <= div_rsp.quotient[15:0] + track_offset + dev_offset;
          wb_sector   <= div_rsp.remainder[15:0];
          wb_buf_high <= slot_high(buffer_base, slot16);
          wb_buf_low  <= slot_low(slot16);
        end
      end
      default: begin
      end
    endcase
  end

  // Checks on the sequencer and the result formatting.
  `DBCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `DBCT_ASSERT_NEXT(a_done_pulse, done, !done, "done strobe lasted more than one cycle")
  `DBCT_ASSERT_NOW(a_wb_zero, done && !wb_valid, wb_track == 16'd0 && wb_sector == 16'd0 && wb_device == 2'd0 && wb_buf_high == 16'd0 && wb_buf_low == 12'd0, "write-back fields set without wb_valid")
  `DBCT_ASSERT_NOW(a_sync_done_alone, done && sync_done, !hit && !wb_valid && buf_high == 16'd0, "sync_done result carries other fields")
  `DBCT_ASSERT_NOW(a_div_owner, div_rsp.done, state == S_WB_DIV, "divider finished outside a waiting state")

endmodule
